### rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator: defaults,
// register indexes, command and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF   = 16;

  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned HEADER_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FIELD_W-1:0]  REGION_RESET = 16'd4096;
  localparam logic [HEADER_W-1:0] HEADER_RESET = 8'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b1;

  // Request commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic start;
    logic scan;
    logic tail;
    logic load_out;
  } dp_cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic count_zero;
    logic count_full;
    logic last_entry;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer of the allocator: takes a request, walks the datapath through
// the table scan and the final update, and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  ffra_pkg::dp_stat_t      stat,
  output ffra_pkg::dp_cmd_t       cmd
);
  import ffra_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_TAIL  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        // A full-table allocate and an empty-table release finish at once; an
        // empty-table allocate only needs the trailing gap check.
        if (!stat.is_free && stat.count_full) begin
          state_next = S_RESP;
        end else if (stat.is_free && stat.count_zero) begin
          state_next = S_RESP;
        end else if (stat.count_zero) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.last_entry) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign cmd.capture  = (state == S_IDLE) && in_valid;
  assign cmd.start    = (state == S_START);
  assign cmd.scan     = (state == S_SCAN);
  assign cmd.tail     = (state == S_TAIL);
  assign cmd.load_out = (state == S_RESP) && stat.out_free;

endmodule

`default_nettype wire

### rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Datapath of the allocator: configuration registers, the sorted entry
// table in a one-write one-read memory, the gap and match logic of the
// scan, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_dp #(
  parameter int unsigned MAX_ENTRIES = ffra_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS   = ffra_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ffra_pkg::FIELD_W-1:0]      cfg_data,
  input  wire logic                              command,
  input  wire logic [ffra_pkg::FIELD_W-1:0]      request_size,
  input  wire logic [ffra_pkg::FIELD_W-1:0]      chunk_address,
  input  ffra_pkg::dp_cmd_t                      cmd,
  output ffra_pkg::dp_stat_t                     stat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   granted,
  output logic [ffra_pkg::FIELD_W-1:0]           result_address,
  output logic [ffra_pkg::STATUS_W-1:0]          status
);
  import ffra_pkg::*;

  localparam int unsigned IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNTW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WIDE  = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int unsigned CW    = WIDE + 3;
  localparam int unsigned NW    = FIELD_W + 1;
  localparam int unsigned SW    = ADDR_BITS + FIELD_W;

  // Configuration.
  logic [FIELD_W-1:0]  region;
  logic [HEADER_W-1:0] header;

  // Request.
  logic                cmd_r;
  logic [FIELD_W-1:0]  size_r;
  logic [FIELD_W-1:0]  addr_r;
  logic [NW-1:0]       needed;

  // Table and scan state.
  logic [SW-1:0]       mem [MAX_ENTRIES];
  logic [SW-1:0]       rd_data;
  logic [IW-1:0]       rd_idx;
  logic                wr_en;
  logic [IW-1:0]       wr_idx;
  logic [SW-1:0]       wr_data;
  logic [CNTW-1:0]     count;
  logic [IW-1:0]       ev_idx;
  logic [CW-1:0]       prev_end;
  logic [SW-1:0]       carry;
  logic                placed;
  logic                found;

  // Pending and delivered result.
  logic                pend_granted;
  logic [FIELD_W-1:0]  pend_addr;
  status_t             pend_status;
  status_t             out_status;

  logic [ADDR_BITS-1:0] d_start;
  logic [FIELD_W-1:0]   d_size;
  logic [CW-1:0]        d_end;
  logic [CW-1:0]        gap_need;
  logic                 fit_here;
  logic                 fit_tail;
  logic [CW-1:0]        chunk_sum;
  logic [ADDR_BITS-1:0] chunk;
  logic                 match;
  logic [CW-1:0]        new_sum;
  logic [ADDR_BITS-1:0] new_chunk;
  logic [SW-1:0]        new_entry;

  assign d_start   = rd_data[SW-1:FIELD_W];
  assign d_size    = rd_data[FIELD_W-1:0];
  assign d_end     = CW'(d_start) + CW'(header) + CW'(d_size);
  assign gap_need  = prev_end + CW'(needed);
  assign fit_here  = CW'(d_start) >= gap_need;
  assign fit_tail  = CW'(region) >= gap_need;
  assign chunk_sum = CW'(d_start) + CW'(header);
  assign chunk     = chunk_sum[ADDR_BITS-1:0];
  assign match     = WIDE'(chunk) == WIDE'(addr_r);
  // The gap start is always below the region size, so prev_end is the new start.
  assign new_sum   = prev_end + CW'(header);
  assign new_chunk = new_sum[ADDR_BITS-1:0];
  assign new_entry = {prev_end[ADDR_BITS-1:0], size_r};

  assign stat.is_free    = (cmd_r == CMD_FREE);
  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count == CNTW'(MAX_ENTRIES));
  assign stat.last_entry = (CNTW'(ev_idx) == count - 1'b1);
  assign stat.out_free   = !out_valid || out_ready;

  // Memory write: an allocate shifts entries up behind the new one, a release
  // shifts entries down over the removed one, one entry per scan cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = ev_idx;
    wr_data = rd_data;
    if (cmd.scan) begin
      if (cmd_r == CMD_ALLOC) begin
        if (placed) begin
          wr_en   = 1'b1;
          wr_data = carry;
        end else if (fit_here) begin
          wr_en   = 1'b1;
          wr_data = new_entry;
        end
      end else if (found) begin
        wr_en  = 1'b1;
        wr_idx = ev_idx - 1'b1;
      end
    end else if (cmd.tail && (cmd_r == CMD_ALLOC)) begin
      wr_idx = count[IW-1:0];
      if (placed) begin
        wr_en   = 1'b1;
        wr_data = carry;
      end else if (fit_tail) begin
        wr_en   = 1'b1;
        wr_data = new_entry;
      end
    end
  end

  assign rd_idx = cmd.scan ? ev_idx + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= command;
      size_r <= request_size;
      addr_r <= chunk_address;
      needed <= NW'(header) + NW'(request_size);
    end
    if (cmd.start) begin
      ev_idx   <= '0;
      prev_end <= '0;
    end else if (cmd.scan) begin
      ev_idx <= ev_idx + 1'b1;
      if ((cmd_r == CMD_ALLOC) && !placed && !fit_here) begin
        prev_end <= d_end;
      end
    end
    if (cmd.scan && (cmd_r == CMD_ALLOC) && (placed || fit_here)) begin
      carry <= rd_data;
    end
    if (cmd.start) begin
      pend_granted <= 1'b0;
      pend_addr    <= '0;
      pend_status  <= (cmd_r == CMD_FREE) ? ST_NOT_FOUND : ST_TABLE_FULL;
    end else if (cmd.tail) begin
      if (cmd_r == CMD_ALLOC) begin
        if (placed || fit_tail) begin
          pend_granted <= 1'b1;
          pend_addr    <= FIELD_W'(new_chunk);
          pend_status  <= ST_OK;
        end else begin
          pend_status  <= ST_NO_SPACE;
        end
      end else if (found) begin
        pend_granted <= 1'b1;
        pend_status  <= ST_OK;
      end else begin
        pend_status  <= ST_NOT_FOUND;
      end
    end
    if (cmd.load_out) begin
      granted        <= pend_granted;
      result_address <= pend_addr;
      out_status     <= pend_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region    <= REGION_RESET;
      header    <= HEADER_RESET;
      count     <= '0;
      placed    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_REGION: region <= cfg_data;
          REG_HEADER: header <= cfg_data[HEADER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        placed <= 1'b0;
        found  <= 1'b0;
      end else if (cmd.scan) begin
        if ((cmd_r == CMD_ALLOC) && fit_here) begin
          placed <= 1'b1;
        end
        if ((cmd_r == CMD_FREE) && match) begin
          found <= 1'b1;
        end
      end
      if (cmd.tail) begin
        if ((cmd_r == CMD_ALLOC) && (placed || fit_tail)) begin
          count <= count + 1'b1;
        end else if ((cmd_r == CMD_FREE) && found) begin
          count <= count - 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status = out_status;

endmodule

`default_nettype wire

### rtl/first_fit_region_allocator.sv
// A request against n live table entries goes from acceptance through a setup step, a scan
// step per entry, an update step and a result step into the output register; an allocate
// on a full table or a release on an empty one skips scan and update. The result step waits
// until the output register is free. The table memory's single read port makes the scan
// read one entry at a time. A new request is accepted only once the last result is loaded.
// Reset empties the table and restores region_bytes = 4096 and header_bytes = 32; no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a fixed region with an address-sorted table of
// live allocations; allocate and release requests, one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator #(
  parameter int unsigned MAX_ENTRIES = ffra_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS   = ffra_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffra_pkg::FIELD_W-1:0]    cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic [ffra_pkg::FIELD_W-1:0]    request_size,
  input  wire logic [ffra_pkg::FIELD_W-1:0]    chunk_address,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 granted,
  output logic [ffra_pkg::FIELD_W-1:0]         result_address,
  output logic [ffra_pkg::STATUS_W-1:0]        status
);
  import ffra_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The user must write configuration only while no request is in flight; the block does not enforce it.
  assign cfg_ready = 1'b1;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffra_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .request_size   (request_size),
    .chunk_address  (chunk_address),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted        (granted),
    .result_address (result_address),
    .status         (status)
  );

endmodule

`default_nettype wire
